[src/mdi_pkg.sv]
// ----------------------------------------------------------------------------
// mdi_pkg - shared types for the modular inverse unit
// Sequencer state encoding.
// ----------------------------------------------------------------------------
package mdi_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_STEP,
    ST_OUT
  } mdi_state_t;

endpackage

[src/mdi_if.sv]
// ----------------------------------------------------------------------------
// mdi_if - valid/ready channels of the modular inverse unit
// Operand input, result output and modulus write channel.
// ----------------------------------------------------------------------------
interface mdi_in_if #(parameter int WORD_WIDTH = 32);
  logic                  valid;
  logic                  ready;
  logic [WORD_WIDTH-1:0] operand_value;

  modport source (output valid, output operand_value, input ready);
  modport sink   (input valid, input operand_value, output ready);
endinterface

interface mdi_out_if #(parameter int WORD_WIDTH = 32);
  logic                  valid;
  logic                  ready;
  logic [WORD_WIDTH-1:0] inverse_value;
  logic                  no_inverse;

  modport source (output valid, output inverse_value, output no_inverse, input ready);
  modport sink   (input valid, input inverse_value, input no_inverse, output ready);
endinterface

interface mdi_cfg_if #(parameter int WORD_WIDTH = 32);
  logic                  valid;
  logic                  ready;
  logic [WORD_WIDTH-1:0] modulus;

  modport source (output valid, output modulus, input ready);
  modport sink   (input valid, input modulus, output ready);
endinterface

[src/mdi_divider.sv]
// ----------------------------------------------------------------------------
// mdi_divider - shift-subtract divider with quotient-times-coefficient
// Restoring division, one quotient bit per cycle, MSB first. Alongside it the
// product quotient * coef is built by Horner accumulation of the same bits.
// ----------------------------------------------------------------------------
module mdi_divider #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [WORD_WIDTH-1:0] dividend,
  input  logic [WORD_WIDTH-1:0] divisor,
  input  logic [WORD_WIDTH-1:0] coef,
  output logic                  done,
  output logic [WORD_WIDTH-1:0] remainder,
  output logic [WORD_WIDTH-1:0] product
);

  localparam int CW = $clog2(WORD_WIDTH + 1);

  logic                  running;
  logic [CW-1:0]         cnt;
  logic [WORD_WIDTH-1:0] dq;
  logic [WORD_WIDTH-1:0] rem;
  logic [WORD_WIDTH-1:0] dvs;
  logic [WORD_WIDTH-1:0] cf;
  logic [WORD_WIDTH-1:0] acc;

  logic [WORD_WIDTH:0]   shifted;
  logic [WORD_WIDTH:0]   diff;
  logic                  qbit;

  always_comb begin
    shifted = {rem, dq[WORD_WIDTH-1]};
    diff    = shifted - {1'b0, dvs};
    qbit    = (shifted >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CW'(WORD_WIDTH);
      end else if (running) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      dvs <= divisor;
      cf  <= coef;
      rem <= '0;
      acc <= '0;
    end else if (running) begin
      dq  <= {dq[WORD_WIDTH-2:0], qbit};
      rem <= qbit ? diff[WORD_WIDTH-1:0] : shifted[WORD_WIDTH-1:0];
      // magnitudes never pass the modulus, so the product fits the word
      acc <= {acc[WORD_WIDTH-2:0], 1'b0} + (qbit ? cf : '0);
    end
  end

  assign remainder = rem;
  assign product   = acc;

endmodule

[src/modular_inverse_unit.sv]
// ----------------------------------------------------------------------------
// modular_inverse_unit - inverse modulo a configured modulus (extended Euclid)
// The shift-subtract divider takes one quotient bit per cycle, once for the
//   reduction and once per Euclid step (at most about 1.44 * WORD_WIDTH steps).
//   One item at a time: operand ready again after the result is taken.
// Reset: modulus returns to 2, sequencer idle, no result pending.
// ----------------------------------------------------------------------------
module modular_inverse_unit #(
  parameter int WORD_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  mdi_in_if.sink    operand,
  mdi_out_if.source result,
  mdi_cfg_if.sink   setup
);

  mdi_pkg::mdi_state_t state, state_next;

  logic [WORD_WIDTH-1:0] modulus;
  logic [WORD_WIDTH-1:0] r0, r1, u0, u1;
  logic                  neg0, neg1;
  logic [WORD_WIDTH-1:0] inverse_value;
  logic                  no_inverse;

  logic                  in_accept;
  logic                  mod_small;
  logic                  div_start;
  logic                  div_done;
  logic [WORD_WIDTH-1:0] div_dividend, div_divisor, div_coef;
  logic [WORD_WIDTH-1:0] div_rem, div_prod;

  assign in_accept = operand.valid && operand.ready;
  assign mod_small = (modulus < WORD_WIDTH'(2));

  // modulus register
  assign setup.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= WORD_WIDTH'(2);
    end else if (setup.valid && setup.ready) begin
      modulus <= setup.modulus;
    end
  end

  // shared divider
  always_comb begin
    if (state == mdi_pkg::ST_IDLE) begin
      div_dividend = operand.operand_value;
      div_divisor  = modulus;
      div_coef     = '0;
    end else begin
      div_dividend = r0;
      div_divisor  = r1;
      div_coef     = u1;
    end
  end

  mdi_divider #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .coef      (div_coef),
    .done      (div_done),
    .remainder (div_rem),
    .product   (div_prod)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mdi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mdi_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_next = mod_small ? mdi_pkg::ST_OUT : mdi_pkg::ST_REDUCE;
        end
      end
      mdi_pkg::ST_REDUCE: begin
        if (div_done) state_next = mdi_pkg::ST_CHECK;
      end
      mdi_pkg::ST_CHECK: begin
        state_next = (r1 == '0) ? mdi_pkg::ST_OUT : mdi_pkg::ST_STEP;
      end
      mdi_pkg::ST_STEP: begin
        if (div_done) state_next = mdi_pkg::ST_CHECK;
      end
      mdi_pkg::ST_OUT: begin
        if (result.ready) state_next = mdi_pkg::ST_IDLE;
      end
      default: state_next = mdi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    operand.ready = (state == mdi_pkg::ST_IDLE);
    result.valid  = (state == mdi_pkg::ST_OUT);
    div_start     = ((state == mdi_pkg::ST_IDLE) && in_accept && !mod_small) ||
                    ((state == mdi_pkg::ST_CHECK) && (r1 != '0));
  end

  // Euclid datapath
  always_ff @(posedge clk) begin
    unique case (state)
      mdi_pkg::ST_IDLE: begin
        if (in_accept && mod_small) begin
          inverse_value <= '0;
          no_inverse    <= 1'b1;
        end
      end
      mdi_pkg::ST_REDUCE: begin
        if (div_done) begin
          r0   <= modulus;
          r1   <= div_rem;
          u0   <= '0;
          neg0 <= 1'b0;
          u1   <= WORD_WIDTH'(1);
          neg1 <= 1'b0;
        end
      end
      mdi_pkg::ST_CHECK: begin
        if (r1 == '0) begin
          if (r0 == WORD_WIDTH'(1)) begin
            inverse_value <= (neg0 && (u0 != '0)) ? (modulus - u0) : u0;
            no_inverse    <= 1'b0;
          end else begin
            inverse_value <= '0;
            no_inverse    <= 1'b1;
          end
        end
      end
      mdi_pkg::ST_STEP: begin
        if (div_done) begin
          r0   <= r1;
          r1   <= div_rem;
          u0   <= u1;
          neg0 <= neg1;
          // coefficients alternate in sign, so magnitudes add
          u1   <= u0 + div_prod;
          neg1 <= !neg1;
        end
      end
      mdi_pkg::ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  assign result.inverse_value = inverse_value;
  assign result.no_inverse    = no_inverse;

`ifndef SYNTH
  a_no_inv_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.no_inverse |-> result.inverse_value == '0)
    else $error("no_inverse result carries a nonzero value");

  a_inv_in_range: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.no_inverse |->
      (result.inverse_value != '0) && (result.inverse_value < modulus))
    else $error("inverse outside 1..modulus-1");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !operand.ready)
    else $error("operand taken again before result delivered");

  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == mdi_pkg::ST_REDUCE) || (state == mdi_pkg::ST_STEP))
    else $error("divider finished outside a divide state");
`endif

endmodule
